/* src/y2r_pkg.sv */
// Package for the 4:2:0 block to RGB565 converter: payload types, arithmetic
// width and BT.601 integer coefficients. No dependencies.
package y2r_pkg;

    // One 2x2 luma block with its shared chroma pair
    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_blk;

    // Four RGB565 pixels
    typedef struct packed {
        logic [15:0] pixel_top_left;
        logic [15:0] pixel_top_right;
        logic [15:0] pixel_bottom_left;
        logic [15:0] pixel_bottom_right;
    } t_pix;

    // Wide enough for 298*239 + 516*128 + 128 with sign
    localparam int TERM_W    = 20;
    localparam int FRAC_BITS = 8;

    typedef logic signed [TERM_W-1:0] t_term;

    localparam logic [7:0] LUMA_FLOOR = 8'd16;

    localparam t_term CHROMA_OFS    = t_term'(128);
    localparam t_term ROUND_HALF    = t_term'(128);
    localparam t_term LIM_LUMA_GAIN = t_term'(298);
    localparam t_term LIM_R_V       = t_term'(409);
    localparam t_term LIM_G_U       = t_term'(100);
    localparam t_term LIM_G_V       = t_term'(208);
    localparam t_term LIM_B_U       = t_term'(516);
    localparam t_term FULL_R_V      = t_term'(359);
    localparam t_term FULL_G_U      = t_term'(88);
    localparam t_term FULL_G_V      = t_term'(183);
    localparam t_term FULL_B_U      = t_term'(454);

endpackage

/* src/y2r_if.sv */
// Handshake channels of the converter: block input, pixel output and the
// mode register write. Depends on y2r_pkg.

interface y2r_blk_if;
    logic          valid;
    logic          ready;
    y2r_pkg::t_blk data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface y2r_pix_if;
    logic          valid;
    logic          ready;
    y2r_pkg::t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface y2r_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/yuv420_to_rgb565_converter.sv */
// Top level: 4:2:0 block to four RGB565 pixels, two register stages.
// Depends on y2r_pkg and the channels in y2r_if.
// A block taken into the input register moves on to the output register before it leaves as a pixel word.
// Throughput: one block per cycle while the pixel side is ready; a stalled result lets
// one more block into the input register, then input ready drops until the result goes.
// Reset (synchronous, active low) empties both stages and selects limited range.
module yuv420_to_rgb565_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    y2r_blk_if.sink       i_blk,
    y2r_pix_if.source     o_pix,
    y2r_cfg_if.sink       i_cfg
);

    logic              r_full_range;
    logic              r_s1_vld;
    y2r_pkg::t_blk     r_s1_blk;
    logic              r_out_vld;
    y2r_pkg::t_pix     r_out_pix;
    y2r_pkg::t_pix     n_out_pix;

    logic              w_s1_take;
    logic              w_s2_take;
    y2r_pkg::t_term    w_u;
    y2r_pkg::t_term    w_v;
    y2r_pkg::t_term    w_tr;
    y2r_pkg::t_term    w_tg;
    y2r_pkg::t_term    w_tb;
    logic [7:0]        w_luma [4];
    logic [15:0]       w_pix  [4];

    // Clamp to 0..255
    function automatic logic [7:0] f_sat(y2r_pkg::t_term c);
        logic [7:0] res;
        if (c[y2r_pkg::TERM_W-1]) begin
            res = 8'd0;
        end else if (|c[y2r_pkg::TERM_W-2:y2r_pkg::FRAC_BITS]) begin
            res = 8'hff;
        end else begin
            res = c[7:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] f_convert(logic [7:0] y, logic full,
                                              y2r_pkg::t_term tr,
                                              y2r_pkg::t_term tg,
                                              y2r_pkg::t_term tb);
        y2r_pkg::t_term l;
        y2r_pkg::t_term r_sum;
        y2r_pkg::t_term g_sum;
        y2r_pkg::t_term b_sum;
        logic [7:0]     rr;
        logic [7:0]     gg;
        logic [7:0]     bb;
        l = (y > y2r_pkg::LUMA_FLOOR)
            ? y2r_pkg::t_term'(y - y2r_pkg::LUMA_FLOOR) * y2r_pkg::LIM_LUMA_GAIN
            : '0;
        if (full) begin
            r_sum = y2r_pkg::t_term'(y) + (tr >>> y2r_pkg::FRAC_BITS);
            g_sum = y2r_pkg::t_term'(y) + (tg >>> y2r_pkg::FRAC_BITS);
            b_sum = y2r_pkg::t_term'(y) + (tb >>> y2r_pkg::FRAC_BITS);
        end else begin
            r_sum = (l + tr + y2r_pkg::ROUND_HALF) >>> y2r_pkg::FRAC_BITS;
            g_sum = (l + tg + y2r_pkg::ROUND_HALF) >>> y2r_pkg::FRAC_BITS;
            b_sum = (l + tb + y2r_pkg::ROUND_HALF) >>> y2r_pkg::FRAC_BITS;
        end
        rr = f_sat(r_sum);
        gg = f_sat(g_sum);
        bb = f_sat(b_sum);
        return {rr[7:3], gg[7:2], bb[7:3]};
    endfunction

    // Advance a stage when the one after it is empty or draining
    assign w_s2_take   = !r_out_vld || o_pix.ready;
    assign w_s1_take   = !r_s1_vld || w_s2_take;
    assign i_blk.ready = w_s1_take;
    assign i_cfg.ready = 1'b1;
    assign o_pix.valid = r_out_vld;
    assign o_pix.data  = r_out_pix;

    assign w_u = y2r_pkg::t_term'(r_s1_blk.chroma_blue) - y2r_pkg::CHROMA_OFS;
    assign w_v = y2r_pkg::t_term'(r_s1_blk.chroma_red) - y2r_pkg::CHROMA_OFS;

    // Chroma terms are shared by all four pixels of the block
    always_comb begin
        if (r_full_range) begin
            w_tr = w_v * y2r_pkg::FULL_R_V;
            w_tg = -(w_u * y2r_pkg::FULL_G_U + w_v * y2r_pkg::FULL_G_V);
            w_tb = w_u * y2r_pkg::FULL_B_U;
        end else begin
            w_tr = w_v * y2r_pkg::LIM_R_V;
            w_tg = -(w_u * y2r_pkg::LIM_G_U + w_v * y2r_pkg::LIM_G_V);
            w_tb = w_u * y2r_pkg::LIM_B_U;
        end
    end

    assign w_luma[0] = r_s1_blk.luma_top_left;
    assign w_luma[1] = r_s1_blk.luma_top_right;
    assign w_luma[2] = r_s1_blk.luma_bottom_left;
    assign w_luma[3] = r_s1_blk.luma_bottom_right;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_pix[k] = f_convert(w_luma[k], r_full_range, w_tr, w_tg, w_tb);
        end
    end

    always_comb begin
        n_out_pix.pixel_top_left     = w_pix[0];
        n_out_pix.pixel_top_right    = w_pix[1];
        n_out_pix.pixel_bottom_left  = w_pix[2];
        n_out_pix.pixel_bottom_right = w_pix[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_range <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_full_range <= i_cfg.data;
            end
            if (w_s1_take) begin
                r_s1_vld <= i_blk.valid;
            end
            if (w_s2_take) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_s1_take && i_blk.valid) begin
            r_s1_blk <= i_blk.data;
        end
        if (w_s2_take && r_s1_vld) begin
            r_out_pix <= n_out_pix;
        end
    end

endmodule

/* src/y2r_checker.sv */
// Port-level checks for the converter, bound to the top level.
// Depends on y2r_pkg and yuv420_to_rgb565_converter.
module y2r_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_blk_valid,
    input logic          i_blk_ready,
    input logic          i_pix_valid,
    input logic          i_pix_ready,
    input y2r_pkg::t_pix i_pix_data
);

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic       w_blk_acc;
    logic       w_pix_acc;

    assign w_blk_acc = i_blk_valid && i_blk_ready;
    assign w_pix_acc = i_pix_valid && i_pix_ready;

    // Words accepted but not yet delivered
    always_comb begin
        n_pending = r_pending;
        if (w_blk_acc && !w_pix_acc) begin
            n_pending = r_pending + 2'd1;
        end else if (!w_blk_acc && w_pix_acc) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two words in flight");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid |-> r_pending != 2'd0)
        else $error("pixel word shown with nothing accepted");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd0 && w_blk_acc) |=> ##1 i_pix_valid)
        else $error("pixel word late on an empty pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !i_pix_ready) |=> (i_pix_valid && $stable(i_pix_data)))
        else $error("stalled pixel word changed");

endmodule

bind yuv420_to_rgb565_converter y2r_checker u_y2r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_blk_valid (i_blk.valid),
    .i_blk_ready (i_blk.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_data  (o_pix.data)
);

/* dv/tb_yuv420_to_rgb565_converter.sv */
`timescale 1ns / 1ps
// Testbench for the 4:2:0 block to RGB565 converter: directed corners, then random blocks
// in both ranges, checked against an in-bench predictor under random idling.
// Depends on y2r_pkg, the channels in y2r_if and the converter top level.
module tb_yuv420_to_rgb565_converter;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int BLOCKS_PER_STEP = 50;
    localparam int DRAIN_CYCLES    = 4;

    // Expected pixel words and the mode they were computed under
    class pixel_tracker;
        bit            full_range;
        int            errors;
        y2r_pkg::t_pix due_pixels[$];

        function int clamp8(int c);
            if (c < 0) begin
                return 0;
            end
            if (c > 255) begin
                return 255;
            end
            return c;
        endfunction

        function logic [15:0] to_rgb565(int y, int tr, int tg, int tb);
            int r;
            int g;
            int b;
            int scaled;
            if (full_range) begin
                r = y + (tr >>> 8);
                g = y + (tg >>> 8);
                b = y + (tb >>> 8);
            end else begin
                scaled = 298 * ((y > 16) ? y - 16 : 0);
                r = (scaled + tr + 128) >>> 8;
                g = (scaled + tg + 128) >>> 8;
                b = (scaled + tb + 128) >>> 8;
            end
            r = clamp8(r);
            g = clamp8(g);
            b = clamp8(b);
            return {r[7:3], g[7:2], b[7:3]};
        endfunction

        function y2r_pkg::t_pix convert_block(y2r_pkg::t_blk blk);
            int            u;
            int            v;
            int            tr;
            int            tg;
            int            tb;
            y2r_pkg::t_pix px;
            u = int'(blk.chroma_blue) - 128;
            v = int'(blk.chroma_red) - 128;
            if (full_range) begin
                tr = 359 * v;
                tg = -(88 * u + 183 * v);
                tb = 454 * u;
            end else begin
                tr = 409 * v;
                tg = -(100 * u + 208 * v);
                tb = 516 * u;
            end
            px.pixel_top_left     = to_rgb565(int'(blk.luma_top_left), tr, tg, tb);
            px.pixel_top_right    = to_rgb565(int'(blk.luma_top_right), tr, tg, tb);
            px.pixel_bottom_left  = to_rgb565(int'(blk.luma_bottom_left), tr, tg, tb);
            px.pixel_bottom_right = to_rgb565(int'(blk.luma_bottom_right), tr, tg, tb);
            return px;
        endfunction

        function void note_block(y2r_pkg::t_blk blk);
            due_pixels.push_back(convert_block(blk));
        endfunction

        function void check_pixels(y2r_pkg::t_pix got);
            y2r_pkg::t_pix want;
            if (due_pixels.size() == 0) begin
                $error("unexpected pixel word %h", got);
                errors++;
                return;
            end
            want = due_pixels.pop_front();
            if (got.pixel_top_left !== want.pixel_top_left) begin
                $error("pixel_top_left: expected %h, got %h",
                       want.pixel_top_left, got.pixel_top_left);
                errors++;
            end
            if (got.pixel_top_right !== want.pixel_top_right) begin
                $error("pixel_top_right: expected %h, got %h",
                       want.pixel_top_right, got.pixel_top_right);
                errors++;
            end
            if (got.pixel_bottom_left !== want.pixel_bottom_left) begin
                $error("pixel_bottom_left: expected %h, got %h",
                       want.pixel_bottom_left, got.pixel_bottom_left);
                errors++;
            end
            if (got.pixel_bottom_right !== want.pixel_bottom_right) begin
                $error("pixel_bottom_right: expected %h, got %h",
                       want.pixel_bottom_right, got.pixel_bottom_right);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    pixel_tracker sb = new();

    y2r_blk_if blk ();
    y2r_pix_if pix ();
    y2r_cfg_if cfg ();

    yuv420_to_rgb565_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk),
        .o_pix   (pix),
        .i_cfg   (cfg)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the pixel side at random
    always @(negedge i_clk) begin
        pix.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) begin
            sb.check_pixels(pix.data);
        end
    end

    function y2r_pkg::t_blk make_block(byte unsigned tl, byte unsigned tr, byte unsigned bl,
                                       byte unsigned br, byte unsigned cb, byte unsigned cr);
        y2r_pkg::t_blk b;
        b.luma_top_left     = tl;
        b.luma_top_right    = tr;
        b.luma_bottom_left  = bl;
        b.luma_bottom_right = br;
        b.chroma_blue       = cb;
        b.chroma_red        = cr;
        return b;
    endfunction

    // Mostly uniform, with extremes, the limited-range luma floor and values near 128 now and then
    function logic [7:0] pick_sample();
        case ($urandom_range(15))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            2: begin
                return 8'd16;
            end
            3: begin
                return 8'($urandom_range(130, 126));
            end
            default: begin
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high on return
    task automatic send_block(y2r_pkg::t_blk b);
        while ($urandom_range(99) < send_idle_pct) begin
            blk.valid = 1'b0;
            @(negedge i_clk);
        end
        blk.valid = 1'b1;
        blk.data  = b;
        forever begin
            @(posedge i_clk);
            if (blk.ready) begin
                sb.note_block(b);
                break;
            end
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        blk.valid = 1'b0;
        while (sb.due_pixels.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_mode(bit full);
        cfg.valid = 1'b1;
        cfg.data  = full;
        forever begin
            @(posedge i_clk);
            if (cfg.ready) begin
                sb.full_range = full;
                break;
            end
            @(negedge i_clk);
        end
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic run_corners();
        y2r_pkg::t_blk corner[12];
        corner[0]  = make_block(0, 0, 0, 0, 0, 0);
        corner[1]  = make_block(255, 255, 255, 255, 255, 255);
        corner[2]  = make_block(0, 15, 16, 17, 128, 128);
        corner[3]  = make_block(235, 240, 254, 255, 128, 128);
        corner[4]  = make_block(16, 128, 235, 255, 0, 0);
        corner[5]  = make_block(16, 128, 235, 255, 255, 255);
        corner[6]  = make_block(0, 64, 192, 255, 0, 255);
        corner[7]  = make_block(0, 64, 192, 255, 255, 0);
        corner[8]  = make_block(128, 128, 128, 128, 128, 128);
        corner[9]  = make_block(1, 2, 4, 8, 1, 254);
        corner[10] = make_block(32, 64, 127, 170, 85, 170);
        corner[11] = make_block(255, 0, 255, 0, 127, 129);
        foreach (corner[k]) begin
            send_block(corner[k]);
        end
    endtask

    initial begin
        int            step;
        y2r_pkg::t_blk b;
        i_rst_n   = 1'b0;
        blk.valid = 1'b0;
        blk.data  = '0;
        cfg.valid = 1'b0;
        cfg.data  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Limited range straight out of reset, then full range
        run_corners();
        drain();
        write_mode(1'b1);
        run_corners();

        // Each idling profile once per range
        for (step = 0; step < 8; step++) begin
            drain();
            write_mode(step[0]);
            case (step >> 1)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 56;
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            repeat (BLOCKS_PER_STEP) begin
                b.luma_top_left     = pick_sample();
                b.luma_top_right    = pick_sample();
                b.luma_bottom_left  = pick_sample();
                b.luma_bottom_right = pick_sample();
                b.chroma_blue       = pick_sample();
                b.chroma_red        = pick_sample();
                send_block(b);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* yuv420_to_rgb565_converter.f */
src/y2r_pkg.sv
src/y2r_if.sv
src/yuv420_to_rgb565_converter.sv
src/y2r_checker.sv
dv/tb_yuv420_to_rgb565_converter.sv
